/* rtl/sram_march_test_sequencer_defines.svh */
// Assertion macros for the march test sequencer checker.
`ifndef SRAM_MARCH_TEST_SEQUENCER_DEFINES_SVH
`define SRAM_MARCH_TEST_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Types, codes and constant tables of the march test sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned SIZE_W      = 19;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned SIZE_WORDS_MAX = (2 ** (SIZE_W - 2)) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BYTES = 1'd1;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_kind_t;

    typedef logic [2:0] pass_t;

    localparam pass_t PASS_W0      = 3'd0;
    localparam pass_t PASS_R0W1R1  = 3'd1;
    localparam pass_t PASS_R1W0R0  = 3'd2;
    localparam pass_t PASS_R0W5R5  = 3'd3;
    localparam pass_t PASS_R5WAR5  = 3'd4;
    localparam pass_t PASS_ADDR_WR = 3'd5;
    localparam pass_t PASS_ADDR_RD = 3'd6;
    localparam pass_t PASS_END     = 3'd7;

    localparam logic [DATA_W-1:0] PAT_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] PAT_ONES = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] PAT_5A   = 32'h5a5a_5a5a;
    localparam logic [DATA_W-1:0] PAT_A5   = 32'ha5a5_a5a5;

    typedef struct packed {
        logic              start_req;
        logic [DATA_W-1:0] read_data;
    } req_word_t;

    typedef struct packed {
        cmd_kind_t         cmd_kind;
        logic [DATA_W-1:0] cmd_addr;
        logic [DATA_W-1:0] cmd_wdata;
        logic              busy_res;
        logic              done_res;
        logic              failed;
        logic [DATA_W-1:0] fail_addr;
        logic [DATA_W-1:0] fail_data;
        logic [DATA_W-1:0] fail_expected;
    } rsp_word_t;

    // Input stage to engine
    typedef struct packed {
        logic      valid;
        req_word_t word;
    } req_stage_t;

    // Data of a march element: sub-op 0 is the leading read, 1 the write, 2 the read-back
    function automatic logic [DATA_W-1:0] march_data(input pass_t pass, input logic [1:0] sub);
        logic [DATA_W-1:0] d;
        d = PAT_ZERO;
        case (pass)
            PASS_R0W1R1: d = (sub == 2'd0) ? PAT_ZERO : PAT_ONES;
            PASS_R1W0R0: d = (sub == 2'd0) ? PAT_ONES : PAT_ZERO;
            PASS_R0W5R5: d = (sub == 2'd0) ? PAT_ZERO : PAT_5A;
            PASS_R5WAR5: d = (sub == 2'd0) ? PAT_5A   : PAT_A5;
            default:     d = PAT_ZERO;
        endcase
        return d;
    endfunction

endpackage

/* rtl/mts_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ifs
// Channel interfaces: request words, result words and register writes.
// ----------------------------------------------------------------------------
interface mts_req_if;
    logic                      valid;
    logic                      ready;
    logic                      start_req;
    logic [mts_pkg::DATA_W-1:0] read_data;

    modport source (output valid, output start_req, output read_data, input ready);
    modport sink   (input valid, input start_req, input read_data, output ready);
endinterface

interface mts_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd_kind;
    logic [mts_pkg::DATA_W-1:0] cmd_addr;
    logic [mts_pkg::DATA_W-1:0] cmd_wdata;
    logic                      busy_res;
    logic                      done_res;
    logic                      failed;
    logic [mts_pkg::DATA_W-1:0] fail_addr;
    logic [mts_pkg::DATA_W-1:0] fail_data;
    logic [mts_pkg::DATA_W-1:0] fail_expected;

    modport source (output valid, output cmd_kind, output cmd_addr, output cmd_wdata,
                    output busy_res, output done_res, output failed, output fail_addr,
                    output fail_data, output fail_expected, input ready);
    modport sink   (input valid, input cmd_kind, input cmd_addr, input cmd_wdata,
                    input busy_res, input done_res, input failed, input fail_addr,
                    input fail_data, input fail_expected, output ready);
endinterface

interface mts_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mts_pkg::CFG_IDX_W-1:0] index;
    logic [mts_pkg::DATA_W-1:0]    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* rtl/mts_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_cfg_regs
// Base address and region size registers; size kept as a saturated word count.
// ----------------------------------------------------------------------------
module mts_cfg_regs #(
    parameter int unsigned MAX_WORDS = 65536
) (
    input  logic                   clk,
    input  logic                   rst_n,
    mts_cfg_if.sink                cfg,
    output logic [31:0]            base_word,
    output logic [$clog2(((MAX_WORDS < mts_pkg::SIZE_WORDS_MAX) ? MAX_WORDS
                          : mts_pkg::SIZE_WORDS_MAX) + 1)-1:0] word_count
);

    localparam int unsigned CAP = (MAX_WORDS < mts_pkg::SIZE_WORDS_MAX) ? MAX_WORDS
                                  : mts_pkg::SIZE_WORDS_MAX;
    localparam int unsigned CW  = $clog2(CAP + 1);
    localparam int unsigned SWW = mts_pkg::SIZE_W - 2;

    logic [29:0]   base_reg;
    logic [CW-1:0] wc_reg;
    logic [SWW-1:0] size_words;

    assign cfg.ready  = 1'b1;
    assign size_words = cfg.wdata[mts_pkg::SIZE_W-1:2];
    assign base_word  = {base_reg, 2'b00};
    assign word_count = wc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            wc_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mts_pkg::CFG_BASE_ADDR:  base_reg <= cfg.wdata[31:2];
                mts_pkg::CFG_SIZE_BYTES:
                begin
                    if (size_words > SWW'(CAP))
                        wc_reg <= CW'(CAP);
                    else
                        wc_reg <= CW'(size_words);
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/mts_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_in_stage
// Input register of the request channel.
// ----------------------------------------------------------------------------
module mts_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    mts_req_if.sink             req,
    input  logic                take,
    output mts_pkg::req_stage_t stage
);

    logic               valid_reg;
    mts_pkg::req_word_t word_reg;

    assign req.ready   = !valid_reg || take;
    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req.ready)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            word_reg.start_req <= req.start_req;
            word_reg.read_data <= req.read_data;
        end
    end

endmodule

/* rtl/mts_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_engine
// March state, one command per word, read check and result register.
// ----------------------------------------------------------------------------
module mts_engine #(
    parameter int unsigned MAX_WORDS = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mts_pkg::req_stage_t stage,
    output logic                take,
    input  logic [31:0]         base_word,
    input  logic [$clog2(((MAX_WORDS < mts_pkg::SIZE_WORDS_MAX) ? MAX_WORDS
                          : mts_pkg::SIZE_WORDS_MAX) + 1)-1:0] word_count,
    mts_rsp_if.source           rsp
);

    localparam int unsigned CAP = (MAX_WORDS < mts_pkg::SIZE_WORDS_MAX) ? MAX_WORDS
                                  : mts_pkg::SIZE_WORDS_MAX;
    localparam int unsigned CW  = $clog2(CAP + 1);

    mts_pkg::pass_t pass_reg, pass_next;
    logic [CW-1:0]  widx_reg, widx_next;
    logic [1:0]     sub_reg, sub_next;
    logic           run_reg, run_next;
    logic           fin_reg, fin_next;
    logic           pend_reg, pend_next;
    logic [31:0]    paddr_reg, paddr_next;
    logic [31:0]    pexp_reg, pexp_next;
    logic           fail_reg, fail_next;
    logic [31:0]    faddr_reg, faddr_next;
    logic [31:0]    fdata_reg, fdata_next;
    logic [31:0]    fexp_reg, fexp_next;

    logic               ov_reg;
    mts_pkg::rsp_word_t out_reg;
    mts_pkg::rsp_word_t out_next;

    logic [CW-1:0]      idx_v;
    logic [1:0]         sub_v;
    logic [2:0]         ops_v;
    logic [31:0]        data_v;

    assign take = stage.valid && (!ov_reg || rsp.ready);

    always_comb
    begin
        pass_next  = pass_reg;
        widx_next  = widx_reg;
        sub_next   = sub_reg;
        run_next   = run_reg;
        fin_next   = fin_reg;
        pend_next  = pend_reg;
        paddr_next = paddr_reg;
        pexp_next  = pexp_reg;
        fail_next  = fail_reg;
        faddr_next = faddr_reg;
        fdata_next = fdata_reg;
        fexp_next  = fexp_reg;
        idx_v      = '0;
        sub_v      = '0;
        ops_v      = 3'd1;
        data_v     = '0;
        out_next   = '0;
        out_next.cmd_kind = mts_pkg::CMD_NONE;

        if (stage.word.start_req)
        begin
            pass_next  = mts_pkg::PASS_W0;
            widx_next  = '0;
            sub_next   = '0;
            run_next   = 1'b1;
            fin_next   = 1'b0;
            pend_next  = 1'b0;
            paddr_next = '0;
            pexp_next  = '0;
            fail_next  = 1'b0;
            faddr_next = '0;
            fdata_next = '0;
            fexp_next  = '0;
        end
        else if (run_reg && pend_reg)
        begin
            pend_next = 1'b0;
            if (stage.word.read_data != pexp_reg)
            begin
                fail_next  = 1'b1;
                faddr_next = paddr_reg;
                fdata_next = stage.word.read_data;
                fexp_next  = pexp_reg;
                run_next   = 1'b0;
                fin_next   = 1'b1;
            end
        end
        else
        begin
            pend_next = 1'b0;
        end

        if (run_next)
        begin
            // pass ended early (region shrank) or empty region
            if (pass_next != mts_pkg::PASS_END && widx_next >= word_count)
            begin
                widx_next = '0;
                sub_next  = '0;
                pass_next = (word_count == '0) ? mts_pkg::PASS_END : pass_next + 3'd1;
            end

            if (pass_next == mts_pkg::PASS_END)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
            else
            begin
                idx_v = (pass_next <= mts_pkg::PASS_R1W0R0) ? widx_next
                        : word_count - CW'(1) - widx_next;
                out_next.cmd_addr = base_word + (32'(idx_v) << 2);

                case (pass_next)
                    mts_pkg::PASS_W0:
                    begin
                        out_next.cmd_kind = mts_pkg::CMD_WRITE;
                        data_v = mts_pkg::PAT_ZERO;
                    end
                    mts_pkg::PASS_ADDR_WR:
                    begin
                        out_next.cmd_kind = mts_pkg::CMD_WRITE;
                        data_v = out_next.cmd_addr;
                    end
                    mts_pkg::PASS_ADDR_RD:
                    begin
                        out_next.cmd_kind = mts_pkg::CMD_READ;
                        data_v = out_next.cmd_addr;
                    end
                    default:
                    begin
                        sub_v = (sub_next > 2'd2) ? 2'd2 : sub_next;
                        out_next.cmd_kind = (sub_v == 2'd1) ? mts_pkg::CMD_WRITE
                                            : mts_pkg::CMD_READ;
                        data_v = mts_pkg::march_data(pass_next, sub_v);
                    end
                endcase

                if (out_next.cmd_kind == mts_pkg::CMD_READ)
                begin
                    pend_next  = 1'b1;
                    paddr_next = out_next.cmd_addr;
                    pexp_next  = data_v;
                    out_next.cmd_wdata = '0;
                end
                else
                begin
                    out_next.cmd_wdata = data_v;
                end

                if (pass_next inside {[mts_pkg::PASS_R0W1R1:mts_pkg::PASS_R5WAR5]})
                    ops_v = 3'd3;
                else
                    ops_v = 3'd1;

                if ({1'b0, sub_next} + 3'd1 >= ops_v)
                begin
                    sub_next  = '0;
                    widx_next = widx_next + CW'(1);
                    if (widx_next >= word_count)
                    begin
                        widx_next = '0;
                        pass_next = pass_next + 3'd1;
                    end
                end
                else
                begin
                    sub_next = sub_next + 2'd1;
                end
            end
        end

        out_next.busy_res      = run_next;
        out_next.done_res      = fin_next;
        out_next.failed        = fail_next;
        out_next.fail_addr     = faddr_next;
        out_next.fail_data     = fdata_next;
        out_next.fail_expected = fexp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg  <= mts_pkg::PASS_W0;
            widx_reg  <= '0;
            sub_reg   <= '0;
            run_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            paddr_reg <= '0;
            pexp_reg  <= '0;
            fail_reg  <= 1'b0;
            faddr_reg <= '0;
            fdata_reg <= '0;
            fexp_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pass_reg  <= pass_next;
                widx_reg  <= widx_next;
                sub_reg   <= sub_next;
                run_reg   <= run_next;
                fin_reg   <= fin_next;
                pend_reg  <= pend_next;
                paddr_reg <= paddr_next;
                pexp_reg  <= pexp_next;
                fail_reg  <= fail_next;
                faddr_reg <= faddr_next;
                fdata_reg <= fdata_next;
                fexp_reg  <= fexp_next;
                ov_reg    <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    assign rsp.valid         = ov_reg;
    assign rsp.cmd_kind      = out_reg.cmd_kind;
    assign rsp.cmd_addr      = out_reg.cmd_addr;
    assign rsp.cmd_wdata     = out_reg.cmd_wdata;
    assign rsp.busy_res      = out_reg.busy_res;
    assign rsp.done_res      = out_reg.done_res;
    assign rsp.failed        = out_reg.failed;
    assign rsp.fail_addr     = out_reg.fail_addr;
    assign rsp.fail_data     = out_reg.fail_data;
    assign rsp.fail_expected = out_reg.fail_expected;

endmodule

/* rtl/sram_march_test_sequencer.sv */
// Path: a request word passes the input register, then the state update into the
// result register; a stall on rsp can hold the word in the input register.
// Throughput: one word per cycle unless rsp stalls; march state steps once per word.
// Reset: all state cleared, registers zero, no word held; no access until start.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sram_march_test_sequencer
// March test command sequencer over a word region with read checking.
// ----------------------------------------------------------------------------
module sram_march_test_sequencer #(
    parameter int unsigned MAX_WORDS = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    mts_cfg_if.sink    cfg,
    mts_req_if.sink    req,
    mts_rsp_if.source  rsp
);

    localparam int unsigned CAP = (MAX_WORDS < mts_pkg::SIZE_WORDS_MAX) ? MAX_WORDS
                                  : mts_pkg::SIZE_WORDS_MAX;
    localparam int unsigned CW  = $clog2(CAP + 1);

    logic [31:0]         base_word;
    logic [CW-1:0]       word_count;
    mts_pkg::req_stage_t stage;
    logic                take;

    mts_cfg_regs #(
        .MAX_WORDS (MAX_WORDS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .base_word  (base_word),
        .word_count (word_count)
    );

    mts_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .stage (stage)
    );

    mts_engine #(
        .MAX_WORDS (MAX_WORDS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .take       (take),
        .base_word  (base_word),
        .word_count (word_count),
        .rsp        (rsp)
    );

endmodule

/* rtl/mts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the result channel.
// ----------------------------------------------------------------------------
`include "sram_march_test_sequencer_defines.svh"

module mts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  cmd_kind,
    input logic [31:0] cmd_addr,
    input logic        busy_res,
    input logic        done_res,
    input logic        failed
);

    `MTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(cmd_kind) && $stable(cmd_addr), "result word changed while stalled")
    `MTS_ASSERT_NOW(a_busy_done, rsp_valid, !(busy_res && done_res), "busy and done both set")
    `MTS_ASSERT_NOW(a_fail_done, rsp_valid && failed, done_res && !busy_res, "failure without done")
    `MTS_ASSERT_NOW(a_cmd_busy, rsp_valid && cmd_kind != mts_pkg::CMD_NONE, busy_res && !failed && cmd_kind != 2'd3, "access issued while not running")

endmodule

bind sram_march_test_sequencer mts_checker u_mts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd_kind  (rsp.cmd_kind),
    .cmd_addr  (rsp.cmd_addr),
    .busy_res  (rsp.busy_res),
    .done_res  (rsp.done_res),
    .failed    (rsp.failed)
);

/* tb/sv/tb_sram_march_test_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sram_march_test_sequencer
// Self-checking bench for the march test sequencer. A queue of request words
// feeds a handshake driver. The driver answers pending reads with the right
// data, with random data or with a flipped bit, and restarts the test at
// random. A built-in march model predicts every command word. The monitor
// compares each command word with the model, field by field. Both channels
// stall at random. Registers change between phases, so some runs see a new
// region while they are still running.
// ----------------------------------------------------------------------------
module tb_sram_march_test_sequencer;

    localparam int unsigned MAX_WORDS    = 65536;
    localparam int unsigned IDLE_PCT     = 23;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned RAND_ITEMS   = 500;

    // index = pass - 1 for the four read/write/read passes
    localparam logic [mts_pkg::DATA_W-1:0] LEAD_PAT [4] =
        '{mts_pkg::PAT_ZERO, mts_pkg::PAT_ONES, mts_pkg::PAT_ZERO, mts_pkg::PAT_5A};
    localparam logic [mts_pkg::DATA_W-1:0] WR_PAT   [4] =
        '{mts_pkg::PAT_ONES, mts_pkg::PAT_ZERO, mts_pkg::PAT_5A, mts_pkg::PAT_A5};

    typedef enum logic [1:0] {
        RD_ECHO,
        RD_RANDOM,
        RD_FLIP
    } rd_mode_t;

    typedef struct {
        logic                       start;
        rd_mode_t                   mode;
        logic [mts_pkg::DATA_W-1:0] rnd;
    } req_step_t;

    logic clk;
    logic rst_n;

    mts_cfg_if cfg_ch ();
    mts_req_if req_ch ();
    mts_rsp_if rsp_ch ();

    sram_march_test_sequencer #(
        .MAX_WORDS(MAX_WORDS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    req_step_t          pending_steps[$];
    mts_pkg::rsp_word_t expected_cmds[$];
    int unsigned        words_sent;
    int unsigned        errors;
    int unsigned        stall_cycles;
    logic               calm;

    // march model
    logic [mts_pkg::DATA_W-1:0] reg_base;
    logic [mts_pkg::SIZE_W-1:0] reg_size;
    int unsigned                pass_n;
    int unsigned                widx;
    int unsigned                subop;
    bit                         running;
    bit                         finished;
    bit                         rd_pend;
    logic [mts_pkg::DATA_W-1:0] pend_addr;
    logic [mts_pkg::DATA_W-1:0] pend_exp;
    bit                         flt;
    logic [mts_pkg::DATA_W-1:0] flt_addr;
    logic [mts_pkg::DATA_W-1:0] flt_data;
    logic [mts_pkg::DATA_W-1:0] flt_exp;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned region_words();
        int unsigned n;
        n = reg_size >> 2;
        if (n > MAX_WORDS)
        begin
            n = MAX_WORDS;
        end
        return n;
    endfunction

    task automatic clear_march();
        pass_n   = 0;
        widx     = 0;
        subop    = 0;
        running  = 1'b0;
        finished = 1'b0;
        rd_pend  = 1'b0;
        pend_addr = '0;
        pend_exp  = '0;
        flt      = 1'b0;
        flt_addr = '0;
        flt_data = '0;
        flt_exp  = '0;
    endtask

    task automatic advance_march(input logic start, input logic [mts_pkg::DATA_W-1:0] rd);
        mts_pkg::rsp_word_t         w;
        mts_pkg::cmd_kind_t         kind;
        logic [mts_pkg::DATA_W-1:0] addr;
        logic [mts_pkg::DATA_W-1:0] wd;
        int unsigned                n;
        int unsigned                idx;
        int unsigned                ops;
        kind = mts_pkg::CMD_NONE;
        addr = '0;
        wd   = '0;
        if (start)
        begin
            clear_march();
            running = 1'b1;
        end
        else if (running && rd_pend)
        begin
            rd_pend = 1'b0;
            if (rd != pend_exp)
            begin
                flt      = 1'b1;
                flt_addr = pend_addr;
                flt_data = rd;
                flt_exp  = pend_exp;
                running  = 1'b0;
                finished = 1'b1;
            end
        end
        else
        begin
            rd_pend = 1'b0;
        end

        if (running)
        begin
            n = region_words();
            while (pass_n < mts_pkg::PASS_END && widx >= n)
            begin
                widx   = 0;
                subop  = 0;
                pass_n = pass_n + 1;
            end
            if (pass_n >= mts_pkg::PASS_END)
            begin
                running  = 1'b0;
                finished = 1'b1;
            end
            else
            begin
                idx  = (pass_n <= mts_pkg::PASS_R1W0R0) ? widx : (n - 1 - widx);
                addr = (reg_base & ~32'h3) + 32'(idx << 2);
                case (pass_n)
                    mts_pkg::PASS_W0:
                    begin
                        kind = mts_pkg::CMD_WRITE;
                        wd   = mts_pkg::PAT_ZERO;
                    end
                    mts_pkg::PASS_ADDR_WR:
                    begin
                        kind = mts_pkg::CMD_WRITE;
                        wd   = addr;
                    end
                    mts_pkg::PASS_ADDR_RD:
                    begin
                        kind = mts_pkg::CMD_READ;
                        wd   = addr;
                    end
                    default:
                    begin
                        kind = (subop == 1) ? mts_pkg::CMD_WRITE : mts_pkg::CMD_READ;
                        wd   = (subop == 0) ? LEAD_PAT[pass_n - 1] : WR_PAT[pass_n - 1];
                    end
                endcase
                if (kind == mts_pkg::CMD_READ)
                begin
                    rd_pend   = 1'b1;
                    pend_addr = addr;
                    pend_exp  = wd;
                    wd        = '0;
                end
                ops   = (pass_n >= mts_pkg::PASS_R0W1R1 && pass_n <= mts_pkg::PASS_R5WAR5)
                        ? 3 : 1;
                subop = subop + 1;
                if (subop >= ops)
                begin
                    subop = 0;
                    widx  = widx + 1;
                    if (widx >= n)
                    begin
                        widx   = 0;
                        pass_n = pass_n + 1;
                    end
                end
            end
        end

        w.cmd_kind      = kind;
        w.cmd_addr      = addr;
        w.cmd_wdata     = wd;
        w.busy_res      = running;
        w.done_res      = finished;
        w.failed        = flt;
        w.fail_addr     = flt_addr;
        w.fail_data     = flt_data;
        w.fail_expected = flt_exp;
        expected_cmds.push_back(w);
    endtask

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (a !== e)
        begin
            errors++;
            $display("%0t %s: expected %h actual %h", $time, name, e, a);
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        req_step_t                  nxt;
        logic [mts_pkg::DATA_W-1:0] rd;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.start_req <= 1'b0;
            req_ch.read_data <= '0;
            calm             <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                advance_march(req_ch.start_req, req_ch.read_data);
                words_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_steps.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_steps.pop_front();
                    rd  = nxt.rnd;
                    if (rd_pend && nxt.mode == RD_ECHO)
                    begin
                        rd = pend_exp;
                    end
                    else if (rd_pend && nxt.mode == RD_FLIP)
                    begin
                        rd = pend_exp ^ (32'h1 << nxt.rnd[4:0]);
                    end
                    req_ch.valid     <= 1'b1;
                    req_ch.start_req <= nxt.start;
                    req_ch.read_data <= rd;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            calm <= (words_sent >= 200 && words_sent < 330);
        end
    end

    // command monitor
    always @(posedge clk)
    begin
        mts_pkg::rsp_word_t e;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: expected none actual kind %h addr %h",
                             $time, rsp_ch.cmd_kind, rsp_ch.cmd_addr);
                end
                else
                begin
                    e = expected_cmds.pop_front();
                    check_field("cmd_kind", 32'(e.cmd_kind), 32'(rsp_ch.cmd_kind));
                    check_field("cmd_addr", e.cmd_addr, rsp_ch.cmd_addr);
                    check_field("cmd_wdata", e.cmd_wdata, rsp_ch.cmd_wdata);
                    check_field("busy_res", 32'(e.busy_res), 32'(rsp_ch.busy_res));
                    check_field("done_res", 32'(e.done_res), 32'(rsp_ch.done_res));
                    check_field("failed", 32'(e.failed), 32'(rsp_ch.failed));
                    check_field("fail_addr", e.fail_addr, rsp_ch.fail_addr);
                    check_field("fail_data", e.fail_data, rsp_ch.fail_data);
                    check_field("fail_expected", e.fail_expected, rsp_ch.fail_expected);
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout at %0t", $time);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_step(input logic start, input rd_mode_t mode);
        req_step_t s;
        s.start = start;
        s.mode  = mode;
        s.rnd   = $urandom();
        pending_steps.push_back(s);
    endtask

    task automatic add_run(input int unsigned cnt, input int unsigned noise_pct);
        repeat (cnt)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                case ($urandom_range(2))
                    0:       add_step(1'b0, RD_RANDOM);
                    1:       add_step(1'b0, RD_FLIP);
                    default: add_step(1'b1, RD_ECHO);
                endcase
            end
            else
            begin
                add_step(1'b0, RD_ECHO);
            end
        end
    endtask

    // sampled away from the rising edge so every update of that edge is seen
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_steps.size() != 0 || req_ch.valid || expected_cmds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mts_pkg::DATA_W-1:0] v);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == mts_pkg::CFG_BASE_ADDR)
        begin
            reg_base = v;
        end
        else
        begin
            reg_size = v[mts_pkg::SIZE_W-1:0];
        end
    endtask

    // wait for the block to go quiet, then retarget the region
    task automatic region(input logic [mts_pkg::DATA_W-1:0] b,
                          input logic [mts_pkg::DATA_W-1:0] sz);
        drain();
        write_reg(mts_pkg::CFG_BASE_ADDR, b);
        write_reg(mts_pkg::CFG_SIZE_BYTES, sz);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned                words;
        int unsigned                len;
        int unsigned                rand_total;
        logic [mts_pkg::DATA_W-1:0] b;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mts_pkg::CFG_BASE_ADDR;
        cfg_ch.wdata = '0;
        req_ch.valid     = 1'b0;
        req_ch.start_req = 1'b0;
        req_ch.read_data = '0;
        rsp_ch.ready = 1'b0;
        calm         = 1'b0;
        words_sent   = 0;
        errors       = 0;
        stall_cycles = 0;
        reg_base     = '0;
        reg_size     = '0;
        clear_march();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle words, then start on an empty region
        add_step(1'b0, RD_RANDOM);
        add_step(1'b0, RD_RANDOM);
        add_step(1'b1, RD_ECHO);
        add_step(1'b0, RD_RANDOM);

        // largest region at the top of the address space: wraps to zero
        region(32'hFFFF_FFFF, 32'h0007_FFFF);
        add_step(1'b1, RD_ECHO);
        add_run(5, 0);

        // shrink mid-run, restart on a pending read, then fail on a bad word
        region(32'hFFFF_FFFF, 32'd8);
        add_step(1'b0, RD_ECHO);
        add_step(1'b1, RD_FLIP);
        add_run(3, 0);
        add_step(1'b0, RD_FLIP);
        add_step(1'b0, RD_ECHO);
        add_step(1'b0, RD_RANDOM);

        region(32'h0, 32'h0);
        add_step(1'b1, RD_RANDOM);

        rand_total = 0;
        while (rand_total < RAND_ITEMS)
        begin
            words = ($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 4);
            case ($urandom_range(2))
                0:       b = 32'hFFFF_FFF0 | $urandom_range(15);
                1:       b = $urandom();
                default: b = $urandom() & 32'h0000_0FFF;
            endcase
            region(b, words * 4 + $urandom_range(3));
            if ($urandom_range(2) == 0)
            begin
                len = $urandom_range(3, 12);
                add_run(len, 0);
                rand_total += len;
            end
            repeat ($urandom_range(1, 3))
            begin
                len = 15 * words + 2 + $urandom_range(2);
                add_step(1'b1, RD_ECHO);
                add_run(len, ($urandom_range(99) < 30) ? 8 : 0);
                rand_total += len + 1;
            end
        end

        drain();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_ifs.sv
rtl/mts_cfg_regs.sv
rtl/mts_in_stage.sv
rtl/mts_engine.sv
rtl/sram_march_test_sequencer.sv
rtl/mts_checker.sv
tb/sv/tb_sram_march_test_sequencer.sv
